// ----- hdl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, request codes, payload structs and the controller state type.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int REQ_W  = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [DATA_W-1:0] value;
    } dq_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] popped_value;
        logic              pop_ok;
        logic              push_dropped;
        logic [CNT_W-1:0]  count_now;
        logic              is_empty;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] back_value;
    } dq_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } dq_state_t;

endpackage

// ----- hdl/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque held in a ring buffer memory with a head pointer, an element
// count and cached front and back words.
// ----------------------------------------------------------------------------
//   Channel   Signals                          Direction
//   request   req_valid, req_stall, req_data   into the block
//   response  rsp_valid, rsp_stall, rsp_data   out of the block
//
// Each request is accepted in ST_IDLE: the memory write or read is issued in the
// accepting cycle and the response is formed from the registered read data
// in ST_FINISH, which a stalled response can hold. The ring memory read is registered.
// Reset empties the queue at once; the memory itself is not cleared.
// A stalled response holds the block in its finishing cycle, and the next
// request is taken once that response has moved into the output register.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  dq_req_t req_data,
    output logic    rsp_valid,
    input  logic    rsp_stall,
    output dq_rsp_t rsp_data
);

    logic [DATA_W-1:0] ring_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    dq_state_t state_reg, state_next;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] back_reg, back_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic              pop_ok_reg, pop_ok_next;
    logic              dropped_reg, dropped_next;
    logic              refresh_front_reg, refresh_front_next;
    logic              refresh_back_reg, refresh_back_next;

    logic              rsp_valid_reg, rsp_valid_next;
    dq_rsp_t           rsp_data_reg, rsp_data_next;

    logic              req_fire;
    logic              finish_fire;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              is_full, is_empty_now;
    logic [DATA_W-1:0] front_cur, back_cur;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall   = 1'b1;
        finish_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_FINISH:
            begin
                finish_fire = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign req_fire = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // Request decode: pointer and count update, memory access
    // ------------------------------------------------------------------
    assign is_full      = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    // A pop leaves a hole in the cache that the memory read fills next cycle.
    assign front_cur = refresh_front_reg ? rd_data_reg : front_reg;
    assign back_cur  = refresh_back_reg  ? rd_data_reg : back_reg;

    always_comb
    begin
        head_next          = head_reg;
        count_next         = count_reg;
        front_next         = front_reg;
        back_next          = back_reg;
        popped_next        = popped_reg;
        pop_ok_next        = pop_ok_reg;
        dropped_next       = dropped_reg;
        refresh_front_next = refresh_front_reg;
        refresh_back_next  = refresh_back_reg;
        wr_en              = 1'b0;
        wr_addr            = head_reg;
        rd_en              = 1'b0;
        rd_addr            = head_reg;

        if (req_fire)
        begin
            popped_next        = '0;
            pop_ok_next        = 1'b0;
            dropped_next       = 1'b0;
            refresh_front_next = 1'b0;
            refresh_back_next  = 1'b0;
            unique case (req_data.req_type)
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = head_reg - ADDR_W'(1);
                        wr_en      = 1'b1;
                        wr_addr    = head_reg - ADDR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                        front_next = req_data.value;
                        if (is_empty_now)
                        begin
                            back_next = req_data.value;
                        end
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_reg + count_reg[ADDR_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        back_next  = req_data.value;
                        if (is_empty_now)
                        begin
                            front_next = req_data.value;
                        end
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (!is_empty_now)
                    begin
                        pop_ok_next        = 1'b1;
                        popped_next        = front_reg;
                        head_next          = head_reg + ADDR_W'(1);
                        count_next         = count_reg - CNT_W'(1);
                        rd_en              = 1'b1;
                        rd_addr            = head_reg + ADDR_W'(1);
                        refresh_front_next = (count_reg != CNT_W'(1));
                    end
                end
                REQ_POP_BACK:
                begin
                    if (!is_empty_now)
                    begin
                        pop_ok_next       = 1'b1;
                        popped_next       = back_reg;
                        count_next        = count_reg - CNT_W'(1);
                        rd_en             = 1'b1;
                        rd_addr           = head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(2);
                        refresh_back_next = (count_reg != CNT_W'(1));
                    end
                end
                default:
                begin
                    // Peek and the unused codes leave the state alone.
                end
            endcase
        end
        else if (finish_fire)
        begin
            front_next         = front_cur;
            back_next          = back_cur;
            refresh_front_next = 1'b0;
            refresh_back_next  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (finish_fire)
        begin
            rsp_valid_next              = 1'b1;
            rsp_data_next.popped_value  = popped_reg;
            rsp_data_next.pop_ok        = pop_ok_reg;
            rsp_data_next.push_dropped  = dropped_reg;
            rsp_data_next.count_now     = count_reg;
            rsp_data_next.is_empty      = is_empty_now;
            rsp_data_next.front_value   = is_empty_now ? '0 : front_cur;
            rsp_data_next.back_value    = is_empty_now ? '0 : back_cur;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            head_reg          <= '0;
            count_reg         <= '0;
            refresh_front_reg <= 1'b0;
            refresh_back_reg  <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            count_reg         <= count_next;
            refresh_front_reg <= refresh_front_next;
            refresh_back_reg  <= refresh_back_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        back_reg     <= back_next;
        popped_reg   <= popped_next;
        pop_ok_reg   <= pop_ok_next;
        dropped_reg  <= dropped_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Ring memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= req_data.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds the queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg)
             || count_reg == $past(count_reg) + CNT_W'(1)
             || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("element count moved by more than one");

    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.pop_ok && rsp_data.push_dropped))
        else $error("response reports both a pop and a dropped push");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.is_empty == (rsp_data.count_now == '0)))
        else $error("empty flag disagrees with the count");

    a_refresh_read: assert property (@(posedge clk) disable iff (!rst_n)
        (refresh_front_reg || refresh_back_reg) |-> state_reg == ST_FINISH)
        else $error("cache refresh pending outside the finishing cycle");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and peek requests into the core and checks every response
// against a ring-buffer predictor kept alongside it. The run covers empty
// corner cases, the spare request codes, a biased random mix under three
// patterns of sender idling and receiver stalling, and a final drain.
// ----------------------------------------------------------------------------
module tb_top;
    import dq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_PRINTED     = 50;
    localparam int WANT_DEPTH      = 8;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    dq_req_t req_data  = '0;
    logic    rsp_valid;
    logic    rsp_stall = 1'b0;
    dq_rsp_t rsp_data;

    // Predictor state: a ring of words, the index of the front and a count.
    logic [DATA_W-1:0] deque_mem [DEPTH];
    int unsigned       deque_head  = 0;
    int unsigned       deque_count = 0;

    // Expected responses in request order, written on acceptance.
    dq_rsp_t     want_buf [WANT_DEPTH];
    int unsigned want_wr       = 0;
    int unsigned want_rd       = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned requests_sent = 0;
    int unsigned rsps_checked  = 0;
    int unsigned drops_seen    = 0;
    int unsigned pops_seen     = 0;
    int unsigned peak_count    = 0;

    double_ended_queue_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned ring_slot(input int unsigned offset);
        return (deque_head + offset) % DEPTH;
    endfunction

    // Applies one request to the predictor and returns the response it expects.
    function automatic dq_rsp_t predict_deque(input dq_req_t req);
        dq_rsp_t rsp;
        rsp = '0;
        case (req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (deque_count >= DEPTH)
                    rsp.push_dropped = 1'b1;
                else
                begin
                    if (req.req_type == REQ_PUSH_FRONT)
                    begin
                        deque_head = ring_slot(DEPTH - 1);
                        deque_mem[deque_head] = req.value;
                    end
                    else
                        deque_mem[ring_slot(deque_count)] = req.value;
                    deque_count++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (deque_count != 0)
                begin
                    rsp.pop_ok = 1'b1;
                    if (req.req_type == REQ_POP_FRONT)
                    begin
                        rsp.popped_value = deque_mem[deque_head];
                        deque_head = ring_slot(1);
                    end
                    else
                        rsp.popped_value = deque_mem[ring_slot(deque_count - 1)];
                    deque_count--;
                end
            end
            default:
            begin
            end
        endcase
        rsp.count_now = deque_count[CNT_W-1:0];
        rsp.is_empty  = (deque_count == 0);
        if (deque_count != 0)
        begin
            rsp.front_value = deque_mem[deque_head];
            rsp.back_value  = deque_mem[ring_slot(deque_count - 1)];
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    // Sends one request, idling beforehand at random, and records the
    // expected response once the core has taken it.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
        dq_req_t req;
        req.req_type = kind;
        req.value    = word;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want_buf[want_wr % WANT_DEPTH] = predict_deque(req);
        want_wr++;
        requests_sent++;
        if (deque_count > peak_count)
            peak_count = deque_count;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // A growing lean favours pushes, a shrinking one favours pops, so the
    // fill level wanders over a wide range.
    function automatic logic [REQ_W-1:0] pick_kind(input bit grow);
        int unsigned roll;
        int unsigned push_pct;
        roll     = $urandom_range(99);
        push_pct = grow ? 70 : 30;
        if (roll < push_pct / 2)
            return REQ_PUSH_FRONT;
        if (roll < push_pct)
            return REQ_PUSH_BACK;
        if (roll < push_pct + (90 - push_pct) / 2)
            return REQ_POP_FRONT;
        if (roll < 90)
            return REQ_POP_BACK;
        if (roll < 95)
            return REQ_PEEK;
        case ($urandom_range(2))
            0:       return REQ_SPARE_5;
            1:       return REQ_SPARE_6;
            default: return REQ_SPARE_7;
        endcase
    endfunction

    task automatic test_directed();
        send_req(REQ_POP_FRONT, 32'h1234_5678);
        send_req(REQ_POP_BACK, 32'hFFFF_FFFF);
        send_req(REQ_PEEK, 32'h0000_0001);
        send_req(REQ_SPARE_5, 32'hDEAD_BEEF);
        send_req(REQ_SPARE_6, 32'h0000_0000);
        // The first push at the front wraps the head round to the last slot.
        send_req(REQ_PUSH_FRONT, 32'h0000_0000);
        send_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_req(REQ_PUSH_BACK, 32'h5A5A_5A5A);
        send_req(REQ_PEEK, 32'hFFFF_FFFF);
        send_req(REQ_SPARE_7, 32'h8000_0001);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_PUSH_BACK, 32'h0000_0001);
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_PUSH_FRONT, 32'h8000_0000);
        send_req(REQ_POP_BACK, 32'h0);
        send_req(REQ_PEEK, 32'h0);
    endtask

    task automatic test_random(input int unsigned num_reqs);
        bit grow;
        grow = 1'b1;
        for (int unsigned i = 0; i < num_reqs; i++)
        begin
            if (i % 20 == 0)
                grow = ($urandom_range(2) != 0);
            send_req(pick_kind(grow), pick_word());
        end
    endtask

    // Drains the queue completely from both ends, then pops past empty.
    task automatic test_drain();
        while (deque_count != 0)
            send_req($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_word());
        send_req(REQ_POP_FRONT, 32'h0);
        send_req(REQ_POP_BACK, 32'h0);
    endtask

    // Response checker; the receiver stall is drawn in the same block so that
    // the handshake is sampled before the new stall value lands.
    always @(posedge clk)
    begin
        dq_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (want_rd == want_wr)
                report_mismatch("unexpected response", DATA_W'(rsp_data.count_now), '0);
            else
            begin
                want = want_buf[want_rd % WANT_DEPTH];
                want_rd++;
                rsps_checked++;
                if (want.push_dropped)
                    drops_seen++;
                if (want.pop_ok)
                    pops_seen++;
                if (rsp_data.popped_value !== want.popped_value)
                    report_mismatch("popped_value", rsp_data.popped_value, want.popped_value);
                if (rsp_data.pop_ok !== want.pop_ok)
                    report_mismatch("pop_ok", DATA_W'(rsp_data.pop_ok), DATA_W'(want.pop_ok));
                if (rsp_data.push_dropped !== want.push_dropped)
                    report_mismatch("push_dropped", DATA_W'(rsp_data.push_dropped),
                                    DATA_W'(want.push_dropped));
                if (rsp_data.count_now !== want.count_now)
                    report_mismatch("count_now", DATA_W'(rsp_data.count_now),
                                    DATA_W'(want.count_now));
                if (rsp_data.is_empty !== want.is_empty)
                    report_mismatch("is_empty", DATA_W'(rsp_data.is_empty),
                                    DATA_W'(want.is_empty));
                if (rsp_data.front_value !== want.front_value)
                    report_mismatch("front_value", rsp_data.front_value, want.front_value);
                if (rsp_data.back_value !== want.back_value)
                    report_mismatch("back_value", rsp_data.back_value, want.back_value);
            end
        end
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycle_count, want_wr - want_rd);
            $display("[double_ended_queue_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        stall_pct     = 79;
        test_directed();
        test_random(160);

        send_idle_pct = 79;
        stall_pct     = 8;
        test_random(160);

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random(160);
        test_drain();

        req_valid <= 1'b0;
        while (want_rd != want_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses; deepest fill %0d of %0d.",
                 requests_sent, rsps_checked, peak_count, DEPTH);
        $display("Saw %0d successful pops, %0d dropped pushes and %0d mismatches.",
                 pops_seen, drops_seen, error_count);
        if (error_count == 0)
            $display("[double_ended_queue_core] OK");
        else
            $display("[double_ended_queue_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dq_pkg.sv
hdl/double_ended_queue_core.sv
verif/tb_top.sv
